### rtl/core/cpvs_pkg.sv
package cpvs_pkg;

    localparam int MAX_FRAMES = 1024;
    localparam int PAGE_BYTES = 4096;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int POOL_W     = FRAME_W + 1;
    localparam int LEN_W      = POOL_W;
    localparam int PASS_W     = 4;
    localparam int CLS_W      = 2;
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_FIND   = 1'b1;

    localparam logic [CLS_W-1:0] CLS_CLEAN = 2'd0;

    localparam logic CFG_POOL_FRAMES  = 1'b0;
    localparam logic CFG_BASE_ADDRESS = 1'b1;

    typedef struct packed {
        logic eligible;
        logic accessed;
        logic dirty;
    } flags_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic               mode;
        logic [FRAME_W-1:0] frame_index;
        flags_t             flags;
        logic [LEN_W-1:0]   sweep_length;
        logic [PASS_W-1:0]  passes;
    } item_t;

    typedef struct packed {
        logic               wr_en;
        logic [FRAME_W-1:0] wr_addr;
        flags_t             wr_data;
        logic               rd_en;
        logic [FRAME_W-1:0] rd_addr;
    } ram_req_t;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] frame;
        logic [CLS_W-1:0]   cls;
    } result_t;

endpackage

### rtl/core/cpvs_flag_ram.sv
module cpvs_flag_ram
    import cpvs_pkg::*;
(
    input  logic     aclk,
    input  ram_req_t req,
    output flags_t   rd_data
);

    flags_t mem [MAX_FRAMES];
    flags_t rd_data_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/cpvs_sweep.sv
module cpvs_sweep
    import cpvs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  item_t             item,
    input  logic [POOL_W-1:0] pool_frames,
    output ram_req_t          ram_req,
    input  flags_t            ram_rd_data,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    state_t             state_reg, state_next;
    logic [FRAME_W-1:0] hand_reg, hand_next;
    logic [FRAME_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [POOL_W-1:0]  pool_reg, pool_next;
    logic [POOL_W-1:0]  len_reg, len_next;
    logic [PASS_W-1:0]  last_pass_reg, last_pass_next;
    logic [PASS_W-1:0]  pass_reg, pass_next;
    logic [FRAME_W-1:0] start_reg, start_next;
    logic [FRAME_W-1:0] addr_reg, addr_next;
    logic [POOL_W-1:0]  cnt_reg, cnt_next;
    logic               issue_on_reg, issue_on_next;
    logic               dv_reg, dv_next;
    logic [FRAME_W-1:0] da_reg, da_next;
    logic               dlast_reg, dlast_next;
    logic               dfinal_reg, dfinal_next;
    logic [FRAME_W-1:0] end_hand_reg, end_hand_next;
    logic               fwd_hit_reg, fwd_hit_next;
    flags_t             fwd_data_reg, fwd_data_next;
    logic [3:1]         have_reg, have_next;
    logic [FRAME_W-1:0] pick_reg [1:3];
    logic [FRAME_W-1:0] pick_next [1:3];
    result_t            res_reg, res_next;

    flags_t             flags_cur;
    logic [CLS_W-1:0]   cls;
    logic [POOL_W-1:0]  pool_eff;
    logic [POOL_W-1:0]  cnt_inc;
    logic [FRAME_W-1:0] addr_inc;
    logic               done_early;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            hand_reg     <= '0;
            clr_cnt_reg  <= '0;
            issue_on_reg <= 1'b0;
            dv_reg       <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            have_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            hand_reg     <= hand_next;
            clr_cnt_reg  <= clr_cnt_next;
            issue_on_reg <= issue_on_next;
            dv_reg       <= dv_next;
            fwd_hit_reg  <= fwd_hit_next;
            have_reg     <= have_next;
        end
    end

    always_ff @(posedge aclk) begin
        pool_reg      <= pool_next;
        len_reg       <= len_next;
        last_pass_reg <= last_pass_next;
        pass_reg      <= pass_next;
        start_reg     <= start_next;
        addr_reg      <= addr_next;
        cnt_reg       <= cnt_next;
        da_reg        <= da_next;
        dlast_reg     <= dlast_next;
        dfinal_reg    <= dfinal_next;
        end_hand_reg  <= end_hand_next;
        fwd_data_reg  <= fwd_data_next;
        pick_reg      <= pick_next;
        res_reg       <= res_next;
    end

    assign flags_cur = fwd_hit_reg ? fwd_data_reg : ram_rd_data;
    assign cls       = {flags_cur.accessed, flags_cur.dirty};
    assign pool_eff  = (pool_frames > POOL_W'(MAX_FRAMES)) ? POOL_W'(MAX_FRAMES) : pool_frames;
    assign cnt_inc   = cnt_reg + POOL_W'(1);
    assign addr_inc  = ((POOL_W'(addr_reg) + POOL_W'(1)) == pool_reg) ? '0
                                                                      : addr_reg + FRAME_W'(1);

    always_comb begin
        state_next     = state_reg;
        hand_next      = hand_reg;
        clr_cnt_next   = clr_cnt_reg;
        pool_next      = pool_reg;
        len_next       = len_reg;
        last_pass_next = last_pass_reg;
        pass_next      = pass_reg;
        start_next     = start_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        issue_on_next  = issue_on_reg;
        dv_next        = 1'b0;
        da_next        = da_reg;
        dlast_next     = dlast_reg;
        dfinal_next    = dfinal_reg;
        end_hand_next  = end_hand_reg;
        have_next      = have_reg;
        pick_next      = pick_reg;
        res_next       = res_reg;
        ram_req        = '0;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        done_early     = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = clr_cnt_reg;
                clr_cnt_next    = clr_cnt_reg + FRAME_W'(1);
                if (clr_cnt_reg == FRAME_W'(MAX_FRAMES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    res_next   = '0;
                    state_next = ST_FINISH;
                    if (item.mode == MODE_UPDATE) begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = item.frame_index;
                        ram_req.wr_data = item.flags;
                    end else if (pool_eff != '0 && item.passes != '0) begin
                        pool_next = pool_eff;
                        if (item.sweep_length == '0 || POOL_W'(item.sweep_length) > pool_eff)
                        begin
                            len_next = pool_eff;
                        end else begin
                            len_next = POOL_W'(item.sweep_length);
                        end
                        last_pass_next = item.passes - PASS_W'(1);
                        pass_next      = '0;
                        start_next     = (POOL_W'(hand_reg) < pool_eff) ? hand_reg : '0;
                        addr_next      = start_next;
                        cnt_next       = '0;
                        issue_on_next  = 1'b1;
                        have_next      = '0;
                        state_next     = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP: begin
                // read stage: one frame address per cycle
                if (issue_on_reg) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = addr_reg;
                    dv_next         = 1'b1;
                    da_next         = addr_reg;
                    dlast_next      = (pass_reg == last_pass_reg);
                    dfinal_next     = (cnt_inc == len_reg) && (pass_reg == last_pass_reg);
                    if (cnt_inc == len_reg) begin
                        cnt_next  = '0;
                        addr_next = start_reg;
                        pass_next = pass_reg + PASS_W'(1);
                        if (pass_reg == last_pass_reg) begin
                            issue_on_next = 1'b0;
                            end_hand_next = addr_inc;
                        end
                    end else begin
                        cnt_next  = cnt_inc;
                        addr_next = addr_inc;
                    end
                end
                // classify stage on the returned flags
                if (dv_reg && flags_cur.eligible) begin
                    if (!dlast_reg && flags_cur.accessed) begin
                        ram_req.wr_en    = 1'b1;
                        ram_req.wr_addr  = da_reg;
                        ram_req.wr_data  = flags_cur;
                        ram_req.wr_data.accessed = 1'b0;
                    end else if (cls == CLS_CLEAN) begin
                        done_early = 1'b1;
                    end else if (!have_reg[cls]) begin
                        have_next[cls] = 1'b1;
                        pick_next[cls] = da_reg;
                    end
                end
                if (done_early) begin
                    res_next.found = 1'b1;
                    res_next.frame = da_reg;
                    res_next.cls   = CLS_CLEAN;
                    hand_next      = da_reg;
                    issue_on_next  = 1'b0;
                    dv_next        = 1'b0;
                    state_next     = ST_FINISH;
                end else if (dv_reg && dfinal_reg) begin
                    hand_next  = end_hand_reg;
                    res_next   = '0;
                    for (int c = 3; c >= 1; c--) begin
                        if (have_next[c]) begin
                            res_next.found = 1'b1;
                            res_next.frame = pick_next[c];
                            res_next.cls   = CLS_W'(c);
                        end
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a write in the cycle of a read to the same frame bypasses the stale read data
        fwd_hit_next  = ram_req.wr_en && ram_req.rd_en && (ram_req.wr_addr == ram_req.rd_addr);
        fwd_data_next = ram_req.wr_data;
    end

    assign res = res_reg;

endmodule

### rtl/core/clock_page_victim_select.sv
// Update item: one flag write; m_tvalid follows through ST_FINISH and the output register.
// Find item: the sweep reads the flags of one frame per cycle from the flag memory, over
// passes * sweep length frames, and ends early when a clean frame is found.
// One item at a time; a result waiting in the output register holds the next one in ST_FINISH.
// After reset (aresetn low, synchronous) the flag memory is cleared, all 1024 frames, with
// s_tready low; registers return to pool_frames 1024, base_address 0, hand 0.
module clock_page_victim_select
    import cpvs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // frame_index[9:0], eligible[10], accessed[11], dirty[12],
                                   // sweep_length[23:13], passes[27:24], zero[31:28]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // victim_frame[9:0], victim_address[41:10],
                                   // victim_class[43:42], zero[47:44]
    output logic        m_tuser,   // found
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    logic [POOL_W-1:0]  pool_frames_reg;
    logic [ADDR_W-1:0]  base_address_reg;
    logic               m_tvalid_reg;
    logic               found_reg;
    logic [FRAME_W-1:0] victim_frame_reg;
    logic [ADDR_W-1:0]  victim_address_reg;
    logic [CLS_W-1:0]   victim_class_reg;

    item_t              item;
    ram_req_t           ram_req;
    flags_t             ram_rd_data;
    logic               res_valid;
    logic               res_ready;
    result_t            res;

    assign item.mode           = s_tuser;
    assign item.frame_index    = s_tdata[9:0];
    assign item.flags.eligible = s_tdata[10];
    assign item.flags.accessed = s_tdata[11];
    assign item.flags.dirty    = s_tdata[12];
    assign item.sweep_length   = s_tdata[23:13];
    assign item.passes         = s_tdata[27:24];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_frames_reg  <= POOL_W'(MAX_FRAMES);
            base_address_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_POOL_FRAMES:  pool_frames_reg  <= cfg_wdata[POOL_W-1:0];
                CFG_BASE_ADDRESS: base_address_reg <= cfg_wdata;
                default:          pool_frames_reg  <= pool_frames_reg;
            endcase
        end
    end

    cpvs_flag_ram u_flag_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    cpvs_sweep u_sweep (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .item        (item),
        .pool_frames (pool_frames_reg),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            found_reg          <= res.found;
            victim_frame_reg   <= res.frame;
            victim_class_reg   <= res.cls;
            victim_address_reg <= res.found
                ? base_address_reg + (ADDR_W'(res.frame) << PAGE_SHIFT)
                : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = {4'b0, victim_class_reg, victim_address_reg, victim_frame_reg};

endmodule
